>>> rtl/tvs_pkg.sv
// ---------------------------------------------------------------------------
// tvs_pkg: shared types and constants of the trilinear volume sampler
// Command and result codes, port widths, queue depths and item layout helpers.
// ---------------------------------------------------------------------------
package tvs_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_DIM_DEF      = 32;
  localparam int NUM_CHANNELS_DEF = 2;
  localparam int NUM_TIMES_DEF    = 2;
  localparam int VOXEL_BITS_DEF   = 16;
  localparam int FRAC_BITS_DEF    = 8;

  // Fixed port widths
  localparam int COORD_W   = 16;
  localparam int VALUE_W   = 16;
  localparam int OUT_W     = 24;
  localparam int OUT_FRAC  = 8;
  localparam int DIM_REG_W = 6;
  localparam int CFG_IDX_W = 2;

  // Queue depths
  localparam int MID_Q_DEPTH = 4;
  localparam int OUT_Q_DEPTH = 8;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_SAMPLE = 2'd1,
    CMD_MASK   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_DEPTH  = 2'd2,
    CFG_UNUSED = 2'd3
  } cfg_e;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_MASK   = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [OUT_W-1:0]   value;
    logic               valid;
    logic               hit;
  } res_t;

  // Address bits per axis inside one parity bank
  function automatic int tvs_hw(int max_dim);
    int w;
    w = $clog2((max_dim + 1) / 2);
    return (w < 1) ? 1 : w;
  endfunction

  // Bank address: time, channel, then z, y, x halves
  function automatic int tvs_aw(int max_dim);
    return 2 + 3 * tvs_hw(max_dim);
  endfunction

  // Queue word: op, flag, parity, eight bank addresses, three fractions, data
  function automatic int tvs_item_w(int max_dim, int frac, int vbits);
    return 2 + 1 + 3 + 8 * tvs_aw(max_dim) + 3 * frac + vbits;
  endfunction

endpackage

>>> rtl/tvs_fifo.sv
// ---------------------------------------------------------------------------
// tvs_fifo: small register queue
// Power-of-two depth, head word visible while not empty.
// ---------------------------------------------------------------------------
module tvs_fifo import tvs_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int CNTW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o,
  output logic             full_o,
  output logic [CNTW-1:0]  count_o
);

  localparam int PW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CNTW-1:0]  cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + PW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNTW'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - CNTW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rd_ptr_q];
  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CNTW'(DEPTH));
  assign count_o = cnt_q;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && full_o |-> pop_i)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue read while empty");

endmodule

>>> rtl/tvs_front.sv
// ---------------------------------------------------------------------------
// tvs_front: input stage of the volume sampler
// Registers one input word, bounds-checks it and builds the bank addresses.
// ---------------------------------------------------------------------------
module tvs_front import tvs_pkg::*; #(
  parameter int MAX_DIM      = MAX_DIM_DEF,
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
  parameter int NUM_TIMES    = NUM_TIMES_DEF,
  parameter int VOXEL_BITS   = VOXEL_BITS_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  localparam int DW     = $clog2(MAX_DIM + 1),
  localparam int ITEM_W = tvs_item_w(MAX_DIM, FRAC_BITS, VOXEL_BITS)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                command_i,
  input  logic signed [COORD_W-1:0] coord_x_i,
  input  logic signed [COORD_W-1:0] coord_y_i,
  input  logic signed [COORD_W-1:0] coord_z_i,
  input  logic                      channel_i,
  input  logic                      time_point_i,
  input  logic [VALUE_W-1:0]        voxel_value_i,
  input  logic [DW-1:0]             dim_w_i,
  input  logic [DW-1:0]             dim_h_i,
  input  logic [DW-1:0]             dim_d_i,
  output logic                      mid_push_o,
  output logic [ITEM_W-1:0]         mid_item_o,
  input  logic                      mid_full_i
);

  localparam int HW = tvs_hw(MAX_DIM);
  localparam int XW = HW + 1;
  localparam int AW = tvs_aw(MAX_DIM);
  localparam int CW = (DW + FRAC_BITS + 1 > COORD_W + 1) ? DW + FRAC_BITS + 1 : COORD_W + 1;
  localparam logic signed [CW-1:0] HALF   = CW'(2 ** (FRAC_BITS - 1));
  localparam logic signed [CW-1:0] ONE_FX = CW'(2 ** FRAC_BITS);

  logic                      f_valid_q, f_valid_d;
  cmd_e                      f_cmd_q;
  logic signed [COORD_W-1:0] f_x_q, f_y_q, f_z_q;
  logic                      f_chan_q, f_time_q;
  logic [VALUE_W-1:0]        f_val_q;

  logic                      accept;
  logic                      keep;
  logic                      leave;
  logic                      vol_ok;
  logic                      is_samp;
  logic                      flag;

  logic signed [COORD_W-1:0] crd [3];
  logic [DW-1:0]             dim [3];
  logic signed [CW-1:0]      cs [3];
  logic signed [CW-1:0]      dimx [3];
  logic signed [CW-1:0]      lim [3];
  logic signed [CW-1:0]      ms [3];
  logic                      samp_in [3];
  logic                      wr_in [3];
  logic                      msk_in [3];
  logic [XW-1:0]             sel [3];
  logic [FRAC_BITS-1:0]      frac [3];
  logic [HW-1:0]             ha [8][3];
  logic [8*AW-1:0]           addr_flat;

  assign crd[0] = f_x_q;
  assign crd[1] = f_y_q;
  assign crd[2] = f_z_q;
  assign dim[0] = dim_w_i;
  assign dim[1] = dim_h_i;
  assign dim[2] = dim_d_i;

  assign vol_ok  = ((NUM_CHANNELS >= 2) || !f_chan_q) && ((NUM_TIMES >= 2) || !f_time_q);
  assign is_samp = (f_cmd_q == CMD_SAMPLE);

  // Per-axis checks and voxel indices
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      cs[a]      = CW'(crd[a]);
      dimx[a]    = CW'(dim[a]);
      lim[a]     = (dimx[a] - CW'(1)) <<< FRAC_BITS;
      samp_in[a] = (cs[a] > CW'(0)) && (cs[a] < lim[a]);
      wr_in[a]   = !cs[a][CW-1] && ((cs[a] >>> FRAC_BITS) < dimx[a]);
      ms[a]      = cs[a] + HALF;
      // truncation toward zero: anything above minus one rounds to voxel 0
      msk_in[a]  = ms[a][CW-1] ? (ms[a] > -ONE_FX) : ((ms[a] >>> FRAC_BITS) < dimx[a]);
      if (f_cmd_q == CMD_MASK) begin
        sel[a] = ms[a][CW-1] ? '0 : ms[a][FRAC_BITS +: XW];
      end else begin
        sel[a] = cs[a][FRAC_BITS +: XW];
      end
      frac[a] = cs[a][FRAC_BITS-1:0];
    end
  end

  // Bank b holds the corner whose parity is b; an odd base index steps
  // the even banks one voxel pair ahead
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      for (int a = 0; a < 3; a++) begin
        ha[b][a] = sel[a][XW-1:1] + HW'(is_samp && sel[a][0] && !b[a]);
      end
      addr_flat[b*AW +: AW] = {f_time_q, f_chan_q, ha[b][2], ha[b][1], ha[b][0]};
    end
  end

  always_comb begin
    keep = 1'b0;
    flag = 1'b0;
    case (f_cmd_q)
      CMD_WRITE: begin
        keep = vol_ok && wr_in[0] && wr_in[1] && wr_in[2];
        flag = 1'b1;
      end
      CMD_SAMPLE: begin
        keep = 1'b1;
        flag = vol_ok && samp_in[0] && samp_in[1] && samp_in[2];
      end
      CMD_MASK: begin
        keep = 1'b1;
        flag = vol_ok && msk_in[0] && msk_in[1] && msk_in[2];
      end
      default: begin
        keep = 1'b0;
        flag = 1'b0;
      end
    endcase
  end

  assign mid_push_o = f_valid_q && keep && !mid_full_i;
  assign mid_item_o = {f_cmd_q, flag, sel[2][0], sel[1][0], sel[0][0], addr_flat,
                       frac[0], frac[1], frac[2], f_val_q[VOXEL_BITS-1:0]};

  // Drop words that cause nothing; otherwise wait for room in the queue
  assign leave      = f_valid_q && (!keep || !mid_full_i);
  assign in_ready_o = !f_valid_q || leave;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    f_valid_d = f_valid_q;
    if (accept) begin
      f_valid_d = 1'b1;
    end else if (leave) begin
      f_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else begin
      f_valid_q <= f_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      f_cmd_q  <= cmd_e'(command_i);
      f_x_q    <= coord_x_i;
      f_y_q    <= coord_y_i;
      f_z_q    <= coord_z_i;
      f_chan_q <= channel_i;
      f_time_q <= time_point_i;
      f_val_q  <= voxel_value_i;
    end
  end

  a_drop_only_idle_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    f_valid_q && (f_cmd_q == CMD_SAMPLE || f_cmd_q == CMD_MASK) && !mid_full_i
    |-> mid_push_o)
    else $error("sample or mask word lost in front stage");

endmodule

>>> rtl/tvs_bank.sv
// ---------------------------------------------------------------------------
// tvs_bank: one parity bank of voxel storage
// Single port, registered read data, contents undefined until written.
// ---------------------------------------------------------------------------
module tvs_bank import tvs_pkg::*; #(
  parameter int AW = 14,
  parameter int DW = 16
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic          we_i,
  input  logic [AW-1:0] addr_i,
  input  logic [DW-1:0] wdata_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2 ** AW];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/tvs_back.sv
// ---------------------------------------------------------------------------
// tvs_back: execution pipeline of the volume sampler
// Eight parity banks, weight products, voxel products and the blend sum.
// ---------------------------------------------------------------------------
module tvs_back import tvs_pkg::*; #(
  parameter int MAX_DIM    = MAX_DIM_DEF,
  parameter int VOXEL_BITS = VOXEL_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  localparam int ITEM_W = tvs_item_w(MAX_DIM, FRAC_BITS, VOXEL_BITS),
  localparam int OCW    = $clog2(OUT_Q_DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [ITEM_W-1:0] item_i,
  input  logic              item_valid_i,
  output logic              item_pop_o,
  input  logic [OCW-1:0]    out_cnt_i,
  output res_t              res_o,
  output logic              res_push_o
);

  localparam int AW   = tvs_aw(MAX_DIM);
  localparam int F    = FRAC_BITS;
  localparam int VB   = VOXEL_BITS;
  localparam int SW   = VB + 3 * F + 1;
  localparam int SH   = 3 * F - OUT_FRAC;
  localparam int O_FZ = VB;
  localparam int O_FY = VB + F;
  localparam int O_FX = VB + 2 * F;
  localparam int O_AD = VB + 3 * F;
  localparam int O_PA = O_AD + 8 * AW;
  localparam int O_FL = O_PA + 3;
  localparam int O_OP = O_FL + 1;
  localparam logic [F:0]    WONE = {1'b1, {F{1'b0}}};
  localparam logic [SW-1:0] RND  = {{(SW-1){1'b0}}, 1'b1} << (SH - 1);

  // Unpacked queue word
  cmd_e          it_op;
  logic          it_flag;
  logic [2:0]    it_par;
  logic [AW-1:0] it_addr [8];
  logic [F-1:0]  it_frac [3];
  logic [VB-1:0] it_data;

  logic          pop;
  logic [2:0]    pending;
  logic [OCW:0]  load;
  logic [7:0]    bank_we;
  logic [VB-1:0] rdata [8];
  logic [F:0]    wv [3][2];

  logic          s1_v_q, s2_v_q, s3_v_q, s4_v_q;
  kind_e         s1_kind_q, s2_kind_q, s3_kind_q, s4_kind_q;
  logic          s1_flag_q, s2_flag_q, s3_flag_q, s4_flag_q;
  logic          s2_hit_q, s3_hit_q, s4_hit_q;
  logic [2:0]    s1_par_q;
  logic [2*F:0]  s1_wxy_q [4];
  logic [2*F:0]  s1_wxy_d [4];
  logic [F:0]    s1_wz_q [2];
  logic [3*F:0]  s2_w8_q [8];
  logic [3*F:0]  s2_w8_d [8];
  logic [VB-1:0] s2_vox_q [8];
  logic [VB-1:0] s2_vox_d [8];
  logic          s2_hit_d;
  logic [SW-1:0] s3_prod_q [8];
  logic [SW-1:0] s3_prod_d [8];
  logic [SW-1:0] s4_quad_q [2];
  logic [SW-1:0] s4_quad_d [2];
  logic [SW-1:0] rsum;
  logic [SW-1:0] shifted;

  assign it_op   = cmd_e'(item_i[O_OP +: 2]);
  assign it_flag = item_i[O_FL];
  assign it_par  = item_i[O_PA +: 3];
  assign it_data = item_i[VB-1:0];
  assign it_frac[0] = item_i[O_FX +: F];
  assign it_frac[1] = item_i[O_FY +: F];
  assign it_frac[2] = item_i[O_FZ +: F];

  // Take a word only if its result is sure to find room in the output queue
  assign pending    = 3'($countones({s1_v_q, s2_v_q, s3_v_q, s4_v_q}));
  assign load       = {1'b0, out_cnt_i} + (OCW+1)'(pending);
  assign pop        = item_valid_i && (load < (OCW+1)'(OUT_Q_DEPTH));
  assign item_pop_o = pop;

  for (genvar gb = 0; gb < 8; gb++) begin : g_bank
    assign it_addr[gb] = item_i[O_AD + gb*AW +: AW];
    assign bank_we[gb] = pop && (it_op == CMD_WRITE) && (it_par == 3'(gb));

    tvs_bank #(
      .AW (AW),
      .DW (VB)
    ) u_bank (
      .clk_i   (clk_i),
      .en_i    (pop),
      .we_i    (bank_we[gb]),
      .addr_i  (it_addr[gb]),
      .wdata_i (it_data),
      .rdata_o (rdata[gb])
    );
  end

  // Stage 0: axis weights and the xy weight products
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      wv[a][1] = {1'b0, it_frac[a]};
      wv[a][0] = WONE - {1'b0, it_frac[a]};
    end
    for (int c = 0; c < 4; c++) begin
      s1_wxy_d[c] = (2*F+1)'(wv[0][c[0]]) * (2*F+1)'(wv[1][c[1]]);
    end
  end

  // Stage 1: full corner weights, voxels put back in corner order
  always_comb begin
    for (int c = 0; c < 8; c++) begin
      s2_w8_d[c]  = (3*F+1)'(s1_wxy_q[c[1:0]]) * (3*F+1)'(s1_wz_q[c[2]]);
      s2_vox_d[c] = rdata[3'(c) ^ s1_par_q];
    end
    s2_hit_d = s1_flag_q && (rdata[s1_par_q] != '0);
  end

  // Stage 2: voxel times weight
  always_comb begin
    for (int c = 0; c < 8; c++) begin
      s3_prod_d[c] = SW'(s2_vox_q[c]) * SW'(s2_w8_q[c]);
    end
  end

  // Stage 3: two partial sums of four
  always_comb begin
    for (int h = 0; h < 2; h++) begin
      s4_quad_d[h] = s3_prod_q[4*h] + s3_prod_q[4*h+1] + s3_prod_q[4*h+2] + s3_prod_q[4*h+3];
    end
  end

  // Stage 4: final add and round to nearest
  assign rsum    = s4_quad_q[0] + s4_quad_q[1] + RND;
  assign shifted = rsum >> SH;

  always_comb begin
    res_o.kind  = s4_kind_q;
    res_o.value = '0;
    res_o.valid = 1'b0;
    res_o.hit   = 1'b0;
    if (s4_kind_q == KIND_MASK) begin
      res_o.hit = s4_hit_q;
    end else if (s4_flag_q) begin
      res_o.value = OUT_W'(shifted);
      res_o.valid = 1'b1;
    end
  end

  assign res_push_o = s4_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else begin
      s1_v_q <= pop && (it_op != CMD_WRITE);
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_kind_q <= (it_op == CMD_MASK) ? KIND_MASK : KIND_SAMPLE;
    s1_flag_q <= it_flag;
    s1_par_q  <= it_par;
    s1_wxy_q  <= s1_wxy_d;
    s1_wz_q   <= wv[2];
    s2_kind_q <= s1_kind_q;
    s2_flag_q <= s1_flag_q;
    s2_hit_q  <= s2_hit_d;
    s2_w8_q   <= s2_w8_d;
    s2_vox_q  <= s2_vox_d;
    s3_kind_q <= s2_kind_q;
    s3_flag_q <= s2_flag_q;
    s3_hit_q  <= s2_hit_q;
    s3_prod_q <= s3_prod_d;
    s4_kind_q <= s3_kind_q;
    s4_flag_q <= s3_flag_q;
    s4_hit_q  <= s3_hit_q;
    s4_quad_q <= s4_quad_d;
  end

  a_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> (out_cnt_i < OCW'(OUT_Q_DEPTH)))
    else $error("result pushed without output queue credit");

endmodule

>>> rtl/trilinear_volume_sampler_core.sv
// ---------------------------------------------------------------------------
// trilinear_volume_sampler_core: voxel store with trilinear sample and mask test
// Path: front register, mid queue, back pipeline, output queue. Throughput: one
// word per cycle unless stalled; eight parity banks give all corners at once.
// Reset: volume sizes go to 32, queues empty; voxels hold nothing defined until
// written and get no clearing pass.
// ---------------------------------------------------------------------------
module trilinear_volume_sampler_core import tvs_pkg::*; #(
  parameter int MAX_DIM      = MAX_DIM_DEF,
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
  parameter int NUM_TIMES    = NUM_TIMES_DEF,
  parameter int VOXEL_BITS   = VOXEL_BITS_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration writes
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_addr_i,
  input  logic [DIM_REG_W-1:0]      cfg_wdata_i,
  // input words
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                command_i,
  input  logic signed [COORD_W-1:0] coord_x_i,
  input  logic signed [COORD_W-1:0] coord_y_i,
  input  logic signed [COORD_W-1:0] coord_z_i,
  input  logic                      channel_i,
  input  logic                      time_point_i,
  input  logic [VALUE_W-1:0]        voxel_value_i,
  // result words
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      result_kind_o,
  output logic [OUT_W-1:0]          sample_value_o,
  output logic                      sample_valid_o,
  output logic                      mask_hit_o
);

  localparam int DW     = $clog2(MAX_DIM + 1);
  localparam int EXW    = (DW > DIM_REG_W) ? DW : DIM_REG_W;
  localparam int ITEM_W = tvs_item_w(MAX_DIM, FRAC_BITS, VOXEL_BITS);
  localparam int OCW    = $clog2(OUT_Q_DEPTH + 1);
  localparam int MCW    = $clog2(MID_Q_DEPTH + 1);

  // Volume size registers, reset to the full 32-voxel cube
  logic [DIM_REG_W-1:0] width_q, height_q, depth_q;
  logic [DW-1:0]        dim_w, dim_h, dim_d;

  // Front to back queue
  logic              mid_push, mid_pop, mid_full, mid_empty;
  logic [ITEM_W-1:0] mid_item_in, mid_item_out;
  logic [MCW-1:0]    mid_cnt;

  // Back to output queue
  res_t              res_in, res_out;
  logic              res_push, out_empty, out_full;
  logic [OCW-1:0]    out_cnt;

  // Clamp a size register into 1..MAX_DIM
  function automatic logic [DW-1:0] sat_dim(logic [DIM_REG_W-1:0] v);
    logic [EXW-1:0] e;
    e = EXW'(v);
    if (e == '0) begin
      return DW'(1);
    end else if (e > EXW'(MAX_DIM)) begin
      return DW'(MAX_DIM);
    end
    return DW'(e);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_REG_W'(32);
      height_q <= DIM_REG_W'(32);
      depth_q  <= DIM_REG_W'(32);
    end else if (cfg_we_i) begin
      case (cfg_e'(cfg_addr_i))
        CFG_WIDTH:  width_q  <= cfg_wdata_i;
        CFG_HEIGHT: height_q <= cfg_wdata_i;
        CFG_DEPTH:  depth_q  <= cfg_wdata_i;
        default: begin
          // unused index: drop the write
        end
      endcase
    end
  end

  assign dim_w = sat_dim(width_q);
  assign dim_h = sat_dim(height_q);
  assign dim_d = sat_dim(depth_q);

  // Front: register the word, check bounds, build the eight bank addresses
  tvs_front #(
    .MAX_DIM      (MAX_DIM),
    .NUM_CHANNELS (NUM_CHANNELS),
    .NUM_TIMES    (NUM_TIMES),
    .VOXEL_BITS   (VOXEL_BITS),
    .FRAC_BITS    (FRAC_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .coord_x_i     (coord_x_i),
    .coord_y_i     (coord_y_i),
    .coord_z_i     (coord_z_i),
    .channel_i     (channel_i),
    .time_point_i  (time_point_i),
    .voxel_value_i (voxel_value_i),
    .dim_w_i       (dim_w),
    .dim_h_i       (dim_h),
    .dim_d_i       (dim_d),
    .mid_push_o    (mid_push),
    .mid_item_o    (mid_item_in),
    .mid_full_i    (mid_full)
  );

  // Short queue so a stalled back end does not stop the input side at once
  tvs_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (MID_Q_DEPTH)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  (mid_item_in),
    .pop_i   (mid_pop),
    .data_o  (mid_item_out),
    .empty_o (mid_empty),
    .full_o  (mid_full),
    .count_o (mid_cnt)
  );

  // Back: bank access in order, so a write is seen by every later read
  tvs_back #(
    .MAX_DIM    (MAX_DIM),
    .VOXEL_BITS (VOXEL_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (mid_item_out),
    .item_valid_i (!mid_empty),
    .item_pop_o   (mid_pop),
    .out_cnt_i    (out_cnt),
    .res_o        (res_in),
    .res_push_o   (res_push)
  );

  // Output queue; the back end holds credit for every result in flight
  tvs_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (OUT_Q_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .pop_i   (out_valid_o && out_ready_i),
    .data_o  (res_out),
    .empty_o (out_empty),
    .full_o  (out_full),
    .count_o (out_cnt)
  );

  assign out_valid_o    = !out_empty;
  assign result_kind_o  = res_out.kind;
  assign sample_value_o = res_out.value;
  assign sample_valid_o = res_out.valid;
  assign mask_hit_o     = res_out.hit;

  a_mask_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o |-> (sample_value_o == '0) && !sample_valid_o)
    else $error("mask result carries sample fields");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !sample_valid_o |-> (sample_value_o == '0))
    else $error("invalid sample with nonzero value");

  a_queue_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mid_cnt <= MCW'(MID_Q_DEPTH)) && !(out_full && res_push && !out_ready_i))
    else $error("queue bound broken");

endmodule
